/* src/lrb_pkg.sv */
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants of the looping audio ring buffer
// Store geometry, pointer widths, sample limits, opcodes and register indexes.
// ----------------------------------------------------------------------------
package lrb_pkg;

  // Store geometry: CHANNELS rows of DEPTH frames
  localparam int DEPTH       = 4096;
  localparam int DEPTH_BITS  = 12;
  localparam int CHANNELS    = 2;
  localparam int CHAN_W      = 1;
  localparam int STORE_DEPTH = CHANNELS * DEPTH;
  localparam int ADDR_W      = CHAN_W + DEPTH_BITS;

  // Pointers hold 0 .. DEPTH inclusive
  localparam int PTR_W    = DEPTH_BITS + 1;
  localparam int OFFSET_W = 14;
  localparam int SUM_W    = OFFSET_W + 1;

  // Q1.23 samples
  localparam int SAMPLE_W = 24;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Configuration registers
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_START    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_END_TRIM = 1'd1;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_ACCUM      = 3'd1,
    OP_READ       = 3'd2,
    OP_READ_CLEAR = 3'd3,
    OP_SET_TAP    = 3'd4,
    OP_SEEK_WRITE = 3'd5
  } opcode_t;

endpackage

/* src/looping_audio_ring_buffer_unit.sv */
// ----------------------------------------------------------------------------
// looping_audio_ring_buffer_unit: multichannel looping audio ring buffer
// Circular sample store with a write pointer and a read tap inside a loop
// region; write, accumulate, read, read-and-clear, set tap and seek write.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis group. tuser carries the opcode and the
//   channel, tdata the sample and the pointer offset, tlast marks the last
//   channel of a frame and advances the pointer that the item used.
//   Every item gives exactly one result on the m_axis group: the sample read
//   (zero unless the item reads) and the pointer position after the item.
//   Each item passes the stage 1 register and then the output register before
//   m_axis_tvalid rises; one item is taken every cycle while results are taken.
//   The store has one read port and one write port: one read at accept, one
//   write as the item leaves stage 1, with a one-deep bypass covering
//   back-to-back accesses to the same sample.
//   Reset clears both pointers and both loop registers, then a clearing pass
//   writes zero to every store entry, one per cycle, CHANNELS * DEPTH = 8192
//   entries in all, while s_axis_tready stays low. Configuration writes are
//   taken at any time but are meant for an idle block.
//   When the receiver stalls the result holds in the output register; one
//   more item may enter the pipeline, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module looping_audio_ring_buffer_unit
  import lrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,  // sample_in[23:0], offset[37:24], zero pad
  input  logic [3:0]             s_axis_tuser,  // opcode[2:0], channel[3]
  input  logic                   s_axis_tlast,  // last_channel
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [39:0]            m_axis_tdata   // sample_out[23:0], position[36:24], zero pad
);

  // --------------------------------------------------------------------------
  // Configuration and pointer state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] loop_start;
  logic [CFG_W-1:0] loop_end_trim;
  logic [PTR_W-1:0] write_position, write_position_next;
  logic [PTR_W-1:0] tap_position, tap_position_next;

  // Clearing pass
  logic              clear_done;
  logic [ADDR_W-1:0] clear_addr;

  // Stage 1: item accepted, store read under way
  logic                       s1_valid;
  opcode_t                    s1_op;
  logic [ADDR_W-1:0]          s1_addr;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [PTR_W-1:0]           s1_pos;
  logic                       s1_fwd;
  logic signed [SAMPLE_W-1:0] s1_fwd_data;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [PTR_W-1:0]           out_pos;

  // Store
  logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];

  // --------------------------------------------------------------------------
  // Input fields
  // --------------------------------------------------------------------------
  opcode_t                    in_op;
  logic [CHAN_W-1:0]          in_chan;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic signed [OFFSET_W-1:0] in_offset;

  assign in_op     = opcode_t'(s_axis_tuser[2:0]);
  assign in_chan   = s_axis_tuser[3];
  assign in_sample = s_axis_tdata[23:0];
  assign in_offset = s_axis_tdata[37:24];

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_adv;
  logic accept;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = clear_done && (!s1_valid || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Loop region and pointer arithmetic
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] region_end;
  logic [PTR_W-1:0] start_pos;

  assign region_end = (int'(loop_end_trim) < DEPTH) ?
                      (PTR_W'(DEPTH) - {1'b0, loop_end_trim}) : '0;
  assign start_pos  = {1'b0, loop_start};

  // Clamp a stored pointer into the region
  function automatic logic [PTR_W-1:0] used_pos(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] lo,
                                                input logic [PTR_W-1:0] hi);
    return (p < lo || p >= hi) ? lo : p;
  endfunction

  // Step past the used frame; may land on the region end, wraps beyond it
  function automatic logic [PTR_W-1:0] step_pos(input logic [PTR_W-1:0] u,
                                                input logic [PTR_W-1:0] lo,
                                                input logic [PTR_W-1:0] hi);
    logic [PTR_W-1:0] n;
    n = u + PTR_W'(1);
    return (n > hi) ? lo : n;
  endfunction

  // Wrap a pointer sum into 0 .. DEPTH; DEPTH is a power of two
  function automatic logic [PTR_W-1:0] wrap_pos(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] m;
    m = s - SUM_W'(1);
    if (s < 0) begin
      return {1'b0, s[DEPTH_BITS-1:0]};
    end else if (s > SUM_W'(DEPTH)) begin
      return {1'b0, m[DEPTH_BITS-1:0]} + PTR_W'(1);
    end else begin
      return s[PTR_W-1:0];
    end
  endfunction

  logic [PTR_W-1:0]        used_write, used_tap;
  logic [PTR_W-1:0]        step_write, step_tap;
  logic signed [SUM_W-1:0] seek_sum;
  logic [PTR_W-1:0]        seek_pos;
  logic [ADDR_W-1:0]       rd_addr;
  logic [PTR_W-1:0]        pos_next;

  assign used_write = used_pos(write_position, start_pos, region_end);
  assign used_tap   = used_pos(tap_position, start_pos, region_end);
  assign step_write = step_pos(used_write, start_pos, region_end);
  assign step_tap   = step_pos(used_tap, start_pos, region_end);
  assign seek_sum   = $signed({2'b00, write_position}) +
                      SUM_W'(in_offset);
  assign seek_pos   = wrap_pos(seek_sum);

  // Decode the item: store address, pointer updates, reported position
  always_comb begin
    write_position_next = write_position;
    tap_position_next   = tap_position;
    rd_addr             = {in_chan, used_write[DEPTH_BITS-1:0]};
    pos_next            = write_position;
    case (in_op)
      OP_WRITE, OP_ACCUM: begin
        if (s_axis_tlast) begin
          write_position_next = step_write;
        end
        pos_next = s_axis_tlast ? step_write : write_position;
      end
      OP_READ, OP_READ_CLEAR: begin
        rd_addr = {in_chan, used_tap[DEPTH_BITS-1:0]};
        if (s_axis_tlast) begin
          tap_position_next = step_tap;
        end
        pos_next = s_axis_tlast ? step_tap : tap_position;
      end
      OP_SET_TAP: begin
        tap_position_next = seek_pos;
        pos_next          = seek_pos;
      end
      OP_SEEK_WRITE: begin
        write_position_next = seek_pos;
        pos_next            = seek_pos;
      end
      default: begin
        pos_next = write_position;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: combine stored sample with the item
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s1_rdata;
  logic signed [SAMPLE_W:0]   acc_sum;
  logic signed [SAMPLE_W-1:0] acc_sat;
  logic signed [SAMPLE_W-1:0] s1_wdata;
  logic                       s1_writes;
  logic                       s1_reads;

  // Bypass the write that landed on the same edge as this item's read
  assign s1_rdata = s1_fwd ? s1_fwd_data : mem_rdata;
  assign acc_sum  = {s1_rdata[SAMPLE_W-1], s1_rdata} +
                    {s1_sample[SAMPLE_W-1], s1_sample};
  assign acc_sat  = (acc_sum[SAMPLE_W] != acc_sum[SAMPLE_W-1]) ?
                    (acc_sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX) :
                    acc_sum[SAMPLE_W-1:0];

  always_comb begin
    s1_writes = 1'b0;
    s1_reads  = 1'b0;
    s1_wdata  = '0;
    case (s1_op)
      OP_WRITE: begin
        s1_writes = 1'b1;
        s1_wdata  = s1_sample;
      end
      OP_ACCUM: begin
        s1_writes = 1'b1;
        s1_wdata  = acc_sat;
      end
      OP_READ: begin
        s1_reads = 1'b1;
      end
      OP_READ_CLEAR: begin
        s1_reads  = 1'b1;
        s1_writes = 1'b1;
      end
      default: begin
        s1_writes = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Store: clearing pass after reset, then item writes
  // --------------------------------------------------------------------------
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  assign mem_we    = !clear_done || (s1_adv && s1_writes);
  assign mem_waddr = clear_done ? s1_addr : clear_addr;
  assign mem_wdata = clear_done ? s1_wdata : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rdata <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_done <= 1'b0;
      clear_addr <= '0;
    end else if (!clear_done) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clear_done <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and pointers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_start    <= '0;
      loop_end_trim <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOOP_START:    loop_start    <= cfg_wdata;
        REG_LOOP_END_TRIM: loop_end_trim <= cfg_wdata;
        default: begin
          loop_start <= loop_start;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      tap_position   <= '0;
    end else if (accept) begin
      write_position <= write_position_next;
      tap_position   <= tap_position_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_fwd   <= s1_adv && s1_writes && (s1_addr == rd_addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= in_op;
      s1_addr     <= rd_addr;
      s1_sample   <= in_sample;
      s1_pos      <= pos_next;
      s1_fwd_data <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample <= s1_reads ? s1_rdata : '0;
      out_pos    <= s1_pos;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_pos, out_sample};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    write_position <= PTR_W'(DEPTH) && tap_position <= PTR_W'(DEPTH))
    else $error("pointer beyond store depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("item accepted into a stalled pipeline");

  a_fwd_owner: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("bypass flag without an item in stage 1");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    !clear_done |-> (!s1_valid && !out_valid))
    else $error("item in flight during clearing pass");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("stage 1 item lost on its way to the output");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the looping audio ring buffer
// Drives opcode items on the input stream, predicts every result in a
// behavioral model of the store, both pointers and the loop region, and
// compares each result item field by field. A directed table comes first,
// then random frames under several loop-region settings and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import lrb_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;  // covers the clearing pass after reset
  localparam int HOLD_CYCLES    = 250;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int PHASES         = 8;
  localparam int PROBE_ROWS     = 25;

  // opcodes the block leaves without effect
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] PAT_A   = 24'sh555555;
  localparam logic signed [SAMPLE_W-1:0] PAT_B   = 24'sh2AAAAA;
  localparam logic signed [SAMPLE_W-1:0] NEG_TWO = -24'sd2;
  localparam logic signed [SAMPLE_W-1:0] ZERO_S  = 24'sd0;

  typedef struct packed {
    logic [2:0]                 op;
    logic                       chan;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [OFFSET_W-1:0] offset;
    logic                       last;
  } ring_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [PTR_W-1:0]           position;
  } ring_result_t;

  typedef struct packed {
    ring_item_t   item;
    logic         use_typed;
    ring_result_t want;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata = '0;  // sample_in[23:0], offset[37:24], zero pad
  logic [3:0]             s_axis_tuser = '0;  // opcode[2:0], channel[3]
  logic                   s_axis_tlast = 1'b0;  // last_channel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [39:0]            m_axis_tdata;  // sample_out[23:0], position[36:24], zero pad

  looping_audio_ring_buffer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Behavioral copy of the buffer state
  logic signed [SAMPLE_W-1:0] store_model [STORE_DEPTH];
  int wr_ptr_m;
  int tap_ptr_m;
  int loop_start_m;
  int loop_trim_m;

  ring_result_t pending_results [$];
  int  mismatches    = 0;
  int  items_sent    = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;
  bit  stall_request = 1'b0;

  // Directed items. Rows with use_typed set carry their result by hand; the
  // rest take the predictor's answer. Loop region is the whole store here.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    // read right after reset: empty store, tap at zero
    '{'{OP_READ,       1'b0, ZERO_S,     14'sd0,    1'b0}, 1'b1, '{ZERO_S,     13'd0}},
    // full-scale samples on both channels of frame zero
    '{'{OP_WRITE,      1'b0, SAMPLE_MAX, 14'sd0,    1'b0}, 1'b1, '{ZERO_S,     13'd0}},
    '{'{OP_WRITE,      1'b1, SAMPLE_MIN, 14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    '{'{OP_SET_TAP,    1'b0, ZERO_S,     -14'sd1,   1'b1}, 1'b1, '{ZERO_S,     13'd0}},
    '{'{OP_SEEK_WRITE, 1'b0, ZERO_S,     -14'sd1,   1'b1}, 1'b1, '{ZERO_S,     13'd0}},
    // accumulate past both rails: saturate
    '{'{OP_ACCUM,      1'b0, 24'sd1,     14'sd0,    1'b0}, 1'b1, '{ZERO_S,     13'd0}},
    '{'{OP_ACCUM,      1'b1, -24'sd1,    14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    '{'{OP_READ,       1'b0, ZERO_S,     14'sd0,    1'b0}, 1'b1, '{SAMPLE_MAX, 13'd0}},
    '{'{OP_READ_CLEAR, 1'b1, ZERO_S,     14'sd0,    1'b1}, 1'b1, '{SAMPLE_MIN, 13'd1}},
    '{'{OP_SET_TAP,    1'b0, ZERO_S,     -14'sd1,   1'b0}, 1'b1, '{ZERO_S,     13'd0}},
    '{'{OP_READ,       1'b1, ZERO_S,     14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    // unused opcodes report the write pointer and change nothing
    '{'{OP_SPARE_6,    1'b1, SAMPLE_MAX, 14'sd5,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    '{'{OP_SPARE_7,    1'b0, SAMPLE_MIN, -14'sd5,   1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    // seek by the largest offset lands exactly on DEPTH
    '{'{OP_SEEK_WRITE, 1'b0, ZERO_S,     14'sd8191, 1'b0}, 1'b1, '{ZERO_S,     13'd4096}},
    // pointer at the region end clamps to loop start before use
    '{'{OP_WRITE,      1'b0, PAT_A,      14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    // most negative seek wraps modulo DEPTH
    '{'{OP_SEEK_WRITE, 1'b0, ZERO_S,    -14'sd8192, 1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    '{'{OP_SET_TAP,    1'b0, ZERO_S,     14'sd4095, 1'b0}, 1'b1, '{ZERO_S,     13'd4096}},
    '{'{OP_READ,       1'b0, ZERO_S,     14'sd0,    1'b1}, 1'b1, '{PAT_A,      13'd1}},
    '{'{OP_SEEK_WRITE, 1'b1, ZERO_S,     14'sd4094, 1'b0}, 1'b1, '{ZERO_S,     13'd4095}},
    // advance from the last frame may equal the region end
    '{'{OP_WRITE,      1'b1, PAT_B,      14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd4096}},
    '{'{OP_WRITE,      1'b0, NEG_TWO,    14'sd0,    1'b1}, 1'b1, '{ZERO_S,     13'd1}},
    '{'{OP_SET_TAP,    1'b1, ZERO_S,     -14'sd2,   1'b1}, 1'b1, '{ZERO_S,     13'd4095}},
    '{'{OP_READ,       1'b1, ZERO_S,     14'sd0,    1'b0}, 1'b1, '{PAT_B,      13'd4095}},
    '{'{OP_READ_CLEAR, 1'b1, ZERO_S,     14'sd0,    1'b1}, 1'b0, '{ZERO_S, 13'd0}},
    '{'{OP_ACCUM,      1'b0, PAT_B,      14'sd0,    1'b1}, 1'b0, '{ZERO_S, 13'd0}}
  };

  initial begin
    forever #4 clk = ~clk;
  end

  // Wrap a signed frame sum into 0 .. DEPTH; DEPTH itself stays put.
  function automatic int wrap_to_depth(int f);
    int r;
    if (f < 0) begin
      r = f % DEPTH;
      if (r < 0) r = r + DEPTH;
    end else if (f > DEPTH) begin
      r = ((f - 1) % DEPTH) + 1;
    end else begin
      r = f;
    end
    return r;
  endfunction

  // Apply one item to the model and return the result it must produce.
  function automatic ring_result_t ring_predict(ring_item_t it);
    int           region_end;
    int           used;
    int           acc;
    int           idx;
    bit           to_write;
    ring_result_t r;
    r.sample   = '0;
    r.position = '0;
    region_end = (loop_trim_m < DEPTH) ? DEPTH - loop_trim_m : 0;
    if (it.op <= OP_READ_CLEAR) begin
      to_write = (it.op <= OP_ACCUM);
      used = to_write ? wr_ptr_m : tap_ptr_m;
      if (used < loop_start_m || used >= region_end) used = loop_start_m;
      idx = int'(it.chan) * DEPTH + used;
      if (used < DEPTH) begin
        case (it.op)
          OP_WRITE: store_model[idx] = it.sample;
          OP_ACCUM: begin
            acc = int'($signed(store_model[idx])) + int'($signed(it.sample));
            if (acc > int'(SAMPLE_MAX)) acc = int'(SAMPLE_MAX);
            if (acc < int'(SAMPLE_MIN)) acc = int'(SAMPLE_MIN);
            store_model[idx] = acc[SAMPLE_W-1:0];
          end
          default: begin
            r.sample = store_model[idx];
            if (it.op == OP_READ_CLEAR) store_model[idx] = '0;
          end
        endcase
      end
      if (it.last) begin
        used = used + 1;
        if (used > region_end) used = loop_start_m;
        if (to_write) wr_ptr_m = used;
        else tap_ptr_m = used;
      end
      acc = to_write ? wr_ptr_m : tap_ptr_m;
    end else if (it.op == OP_SET_TAP) begin
      tap_ptr_m = wrap_to_depth(wr_ptr_m + int'($signed(it.offset)));
      acc = tap_ptr_m;
    end else if (it.op == OP_SEEK_WRITE) begin
      wr_ptr_m = wrap_to_depth(wr_ptr_m + int'($signed(it.offset)));
      acc = wr_ptr_m;
    end else begin
      acc = wr_ptr_m;
    end
    r.position = acc[PTR_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return SAMPLE_MAX;
    if (pick < 24) return SAMPLE_MIN;
    return SAMPLE_W'($urandom);
  endfunction

  // Offer one item, hold it until taken, then record what it must produce.
  task automatic send_item(input ring_item_t it, input logic use_typed,
                           input ring_result_t want);
    ring_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {10'b0, it.offset, it.sample};
    s_axis_tuser  <= {it.chan, it.op};
    s_axis_tlast  <= it.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = ring_predict(it);
    pending_results.push_back(use_typed ? want : got);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_loop_regs(input logic [CFG_W-1:0] start,
                                 input logic [CFG_W-1:0] trim);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LOOP_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= REG_LOOP_END_TRIM;
    cfg_wdata <= trim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    loop_start_m = int'(start);
    loop_trim_m  = int'(trim);
  endtask

  // One random burst: mostly whole frames, some pointer moves, some noise.
  task automatic send_random_burst();
    ring_item_t   it;
    ring_result_t none;
    int           pick;
    int           c;
    bit           group_write;
    none = '0;
    pick = $urandom_range(99);
    it.sample = rand_sample();
    it.offset = OFFSET_W'($urandom_range(16383));
    it.chan   = 1'($urandom_range(1));
    it.last   = 1'($urandom_range(1));
    if (pick < 60) begin
      // well-formed frame: every channel, last flag on the final one
      group_write = 1'($urandom_range(1));
      for (c = 0; c < CHANNELS; c++) begin
        if (group_write) it.op = ($urandom_range(2) == 0) ? OP_ACCUM : OP_WRITE;
        else it.op = ($urandom_range(3) == 0) ? OP_READ_CLEAR : OP_READ;
        it.chan   = c[CHAN_W-1:0];
        it.sample = rand_sample();
        it.last   = (c == CHANNELS - 1);
        send_item(it, 1'b0, none);
        items_sent++;
      end
    end else if (pick < 74) begin
      // put the tap a little behind the write pointer so reads find data
      it.op = OP_SET_TAP;
      if ($urandom_range(3) != 0) it.offset = -OFFSET_W'($urandom_range(48));
      send_item(it, 1'b0, none);
      items_sent++;
    end else if (pick < 84) begin
      it.op = OP_SEEK_WRITE;
      if ($urandom_range(2) == 0) it.offset = OFFSET_W'($urandom_range(8));
      else if ($urandom_range(1) == 0) it.offset = -OFFSET_W'($urandom_range(8));
      send_item(it, 1'b0, none);
      items_sent++;
    end else begin
      // noise: any opcode, channel and flag
      it.op = 3'($urandom_range(7));
      send_item(it, 1'b0, none);
      if (it.op <= OP_SEEK_WRITE) items_sent++;
    end
  endtask

  // Check results and drive the receiver's ready, with random or long stalls.
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, sample_out %0d position %0d",
                 $time, $signed(m_axis_tdata[23:0]), m_axis_tdata[36:24]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[23:0] !== want.sample) begin
          $display("%0t: sample_out mismatch, expected %0d actual %0d", $time,
                   $signed(want.sample), $signed(m_axis_tdata[23:0]));
          mismatches++;
        end
        if (m_axis_tdata[36:24] !== want.position) begin
          $display("%0t: position mismatch, expected %0d actual %0d", $time,
                   want.position, m_axis_tdata[36:24]);
          mismatches++;
        end
      end
    end
    if (stall_request) begin
      hold_left     = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int               ph;
    int               r;
    int               quota;
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] trim;
    foreach (store_model[i]) store_model[i] = '0;
    wr_ptr_m     = 0;
    tap_ptr_m    = 0;
    loop_start_m = 0;
    loop_trim_m  = 0;
    send_idle_pct = 36;
    recv_idle_pct = 70;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset loop region
    for (r = 0; r < PROBE_ROWS; r++) begin
      send_item(probe_rows[r].item, probe_rows[r].use_typed, probe_rows[r].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle_results();
      case (ph)
        0: begin start = 12'd0;    trim = 12'd0;    end
        1: begin start = 12'd4095; trim = 12'd4095; end  // region empty, start past end
        2: begin start = 12'd100;  trim = 12'd3900; end
        3: begin start = 12'd0;    trim = 12'd4095; end  // one-frame region at zero
        4: begin start = 12'd4095; trim = 12'd0;    end  // one-frame region at the top
        5: begin
          start = CFG_W'($urandom_range(64));
          trim  = CFG_W'(DEPTH - int'(start) - int'($urandom_range(1, 48)));
        end
        6: begin
          start = CFG_W'($urandom_range(4095));
          trim  = CFG_W'($urandom_range(4095));
        end
        default: begin start = 12'd8; trim = 12'd4000; end
      endcase
      write_loop_regs(start, trim);
      if (ph < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 70;
      end else if (ph < 6) begin
        send_idle_pct = 70;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold while the sender keeps offering: fill and back up
      if (ph == PHASES - 1) stall_request = 1'b1;
      quota = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < quota) send_random_burst();
    end

    settle_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/lrb_pkg.sv
src/looping_audio_ring_buffer_unit.sv
sim/tb_top.sv
